// File: hdl/dtlm_pkg.sv
`default_nettype none

package dtlm_pkg;

    // Widest table index and widest per-scan expiry count (table depth up to 65536).
    localparam int IDX_W = 16;
    localparam int EXP_W = 17;

    // Opcodes of an input request.
    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_SWEEP  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [3:0] ST_IGNORED = 4'd0;
    localparam logic [3:0] ST_STORED  = 4'd1;
    localparam logic [3:0] ST_FULL    = 4'd2;
    localparam logic [3:0] ST_UNKNOWN = 4'd3;
    localparam logic [3:0] ST_TIMEOUT = 4'd4;
    localparam logic [3:0] ST_SUCCESS = 4'd5;
    localparam logic [3:0] ST_FAIL    = 4'd6;
    localparam logic [3:0] ST_SWEEP   = 4'd7;
    localparam logic [3:0] ST_CLEARED = 4'd8;

    // Configuration register indexes.
    localparam logic [1:0] REG_AA_CODE   = 2'd0;
    localparam logic [1:0] REG_TERM_CODE = 2'd1;
    localparam logic [1:0] REG_RTT_LIMIT = 2'd2;
    localparam logic [1:0] REG_TIMEOUT   = 2'd3;

    // Result code rule for a successful answer.
    localparam logic [31:0] SUCCESS_BELOW   = 32'd3000;
    localparam logic [31:0] SUCCESS_SPECIAL = 32'd70001;

    // Round trip saturation limits.
    localparam logic [47:0] RT_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] RT_NEG_MAG = 48'h8000_0000_0000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [23:0] command_code;
        logic        is_request;
        logic [31:0] hop_id;
        logic [47:0] time_stamp;
        logic [31:0] result_code;
    } req_t;

    typedef struct packed {
        logic [3:0]         status;
        logic               msg_type;
        logic signed [47:0] round_trip;
        logic [31:0]        attempts_count;
        logic [31:0]        success_count;
        logic [31:0]        fail_count;
        logic [31:0]        timeout_count;
        logic [31:0]        unknown_count;
        logic [63:0]        latency_sum;
        logic [31:0]        latency_count;
        logic               last;
    } res_t;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic             act;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [47:0]      hit_time;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic [EXP_W-1:0] exp0;
        logic [EXP_W-1:0] exp1;
    } tok_t;

    // Search key and sweep limits shared by every cell.
    typedef struct packed {
        logic        sweep;
        logic        typ;
        logic [31:0] hop;
        logic [47:0] ts;
        logic [47:0] timeout;
    } bcast_t;

    // Entry write from the controller: set stores an entry, otherwise it is erased.
    typedef struct packed {
        logic             en;
        logic             set;
        logic [IDX_W-1:0] idx;
        logic             typ;
        logic [31:0]      hop;
        logic [47:0]      tim;
    } wr_t;

    // Per-type statistics.
    typedef struct packed {
        logic [31:0] att;
        logic [31:0] suc;
        logic [31:0] fail;
        logic [31:0] tmo;
        logic [31:0] unk;
        logic [63:0] sum;
        logic [31:0] lcnt;
    } cnt_t;

    // Saturating add of a small count to a 32-bit counter.
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [EXP_W-1:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/dtlm_cell.sv
`default_nettype none

module dtlm_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dtlm_pkg::bcast_t key,
    input  wire dtlm_pkg::wr_t    wr,
    input  wire dtlm_pkg::tok_t   tok_in,
    output dtlm_pkg::tok_t        tok_out
);

    logic              valid_reg, valid_next;
    logic              typ_reg;
    logic [31:0]       hop_reg;
    logic [47:0]       tim_reg;
    dtlm_pkg::tok_t    tok_reg, tok_next;
    logic              wr_hit;
    logic              expired;
    logic [48:0]       deadline;

    assign wr_hit   = wr.en && (wr.idx == dtlm_pkg::IDX_W'(CELL_IDX));
    assign deadline = {1'b0, tim_reg} + {1'b0, key.timeout};
    assign expired  = valid_reg && (deadline < {1'b0, key.ts});

    // Token update as it passes this entry.
    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        if (tok_in.act)
        begin
            if (key.sweep)
            begin
                if (expired)
                begin
                    valid_next = 1'b0;
                    if (typ_reg)
                        tok_next.exp1 = tok_in.exp1 + dtlm_pkg::EXP_W'(1);
                    else
                        tok_next.exp0 = tok_in.exp0 + dtlm_pkg::EXP_W'(1);
                end
            end
            else
            begin
                if (!tok_in.hit && valid_reg && typ_reg == key.typ && hop_reg == key.hop)
                begin
                    tok_next.hit      = 1'b1;
                    tok_next.hit_idx  = dtlm_pkg::IDX_W'(CELL_IDX);
                    tok_next.hit_time = tim_reg;
                end
                if (!tok_in.free && !valid_reg)
                begin
                    tok_next.free     = 1'b1;
                    tok_next.free_idx = dtlm_pkg::IDX_W'(CELL_IDX);
                end
            end
        end
        else if (wr_hit)
        begin
            valid_next = wr.set;
        end
    end

    // Valid bit and outgoing token.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // Entry payload.
    always_ff @(posedge clk)
    begin
        if (wr_hit && wr.set && !tok_in.act)
        begin
            typ_reg <= wr.typ;
            hop_reg <= wr.hop;
            tim_reg <= wr.tim;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// File: hdl/diameter_transaction_latency_monitor.sv
`default_nettype none

// Diameter transaction latency monitor. Raise start with a request while busy is low.
// Requests whose command code matches neither type register, and opcode 3, give their
// single result on the next cycle without going busy. A clear gives two results, from
// the states S_EMIT0 and S_EMIT1 in turn. A packet or a sweep sends a token down the
// row of TABLE_DEPTH entry cells, one cell per cycle; when it leaves the row, a packet
// gives one result from S_EMIT and a sweep gives two results from S_EMIT0 and S_EMIT1.
// Each result shows on result for exactly one cycle with result_valid high and cannot be
// held off; the last result of a request has last set.
// Configuration writes through wr_en, wr_index and wr_data take effect at once.
module diameter_transaction_latency_monitor #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire dtlm_pkg::req_t   request,
    input  wire logic             wr_en,
    input  wire logic [1:0]       wr_index,
    input  wire logic [47:0]      wr_data,
    output logic                  result_valid,
    output dtlm_pkg::res_t        result
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EMIT  = 3'd2;
    localparam logic [2:0] S_EMIT0 = 3'd3;
    localparam logic [2:0] S_EMIT1 = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [23:0]        aa_reg, term_reg;
    logic [47:0]        limit_reg, timeout_reg;
    dtlm_pkg::req_t     item_reg, item_next;
    logic               typ_reg, typ_next;
    logic [3:0]         status_reg, status_next;
    logic [47:0]        rt_reg, rt_next;
    logic               tok_start_reg, tok_start_next;
    dtlm_pkg::wr_t      wr_reg, wr_next;
    dtlm_pkg::cnt_t     cnt_reg [2];
    dtlm_pkg::cnt_t     cnt_next [2];
    dtlm_pkg::res_t     result_reg, result_next;
    logic               result_valid_reg, result_valid_next;
    dtlm_pkg::tok_t     tok [TABLE_DEPTH+1];
    dtlm_pkg::tok_t     tok_end;
    dtlm_pkg::bcast_t   key;
    logic               accept;
    logic               is_aa, is_term;
    logic [47:0]        diff_pos, diff_neg;
    logic               negative;
    logic               too_long;
    logic [64:0]        sum_ext;
    logic               good_code;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign is_aa   = (request.command_code == aa_reg);
    assign is_term = (request.command_code == term_reg);

    // Shared search key for the cell row.
    assign key.sweep   = (item_reg.opcode == dtlm_pkg::OP_SWEEP);
    assign key.typ     = typ_reg;
    assign key.hop     = item_reg.hop_id;
    assign key.ts      = item_reg.time_stamp;
    assign key.timeout = timeout_reg;

    assign tok[0] = '{act: tok_start_reg, default: '0};

    // Row of table entry cells.
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        dtlm_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .key     (key),
            .wr      (wr_reg),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign tok_end = tok[TABLE_DEPTH];

    // Round trip of a matched answer.
    assign negative  = (item_reg.time_stamp < tok_end.hit_time);
    assign diff_pos  = item_reg.time_stamp - tok_end.hit_time;
    assign diff_neg  = tok_end.hit_time - item_reg.time_stamp;
    assign too_long  = negative || (diff_pos > limit_reg);
    assign sum_ext   = {1'b0, cnt_reg[typ_reg].sum} + {17'd0, diff_pos};
    assign good_code = (item_reg.result_code < dtlm_pkg::SUCCESS_BELOW)
                    || (item_reg.result_code == dtlm_pkg::SUCCESS_SPECIAL);

    // Controller.
    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        typ_next          = typ_reg;
        status_next       = status_reg;
        rt_next           = rt_reg;
        tok_start_next    = 1'b0;
        wr_next           = '0;
        cnt_next          = cnt_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = request;
                    typ_next  = !is_aa;
                    rt_next   = '0;
                    if (request.opcode == dtlm_pkg::OP_CLEAR)
                    begin
                        cnt_next[0] = '0;
                        cnt_next[1] = '0;
                        status_next = dtlm_pkg::ST_CLEARED;
                        state_next  = S_EMIT0;
                    end
                    else if (request.opcode == dtlm_pkg::OP_SWEEP
                          || (request.opcode == dtlm_pkg::OP_PACKET && (is_aa || is_term)))
                    begin
                        tok_start_next = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        result_next       = '0;
                        result_next.last  = 1'b1;
                        result_valid_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (tok_end.act)
                begin
                    state_next = S_EMIT;
                    if (key.sweep)
                    begin
                        cnt_next[0].tmo = dtlm_pkg::sat_add32(cnt_reg[0].tmo, tok_end.exp0);
                        cnt_next[0].att = dtlm_pkg::sat_add32(cnt_reg[0].att, tok_end.exp0);
                        cnt_next[1].tmo = dtlm_pkg::sat_add32(cnt_reg[1].tmo, tok_end.exp1);
                        cnt_next[1].att = dtlm_pkg::sat_add32(cnt_reg[1].att, tok_end.exp1);
                        status_next     = dtlm_pkg::ST_SWEEP;
                        state_next      = S_EMIT0;
                    end
                    else if (item_reg.is_request)
                    begin
                        wr_next.set = 1'b1;
                        wr_next.typ = typ_reg;
                        wr_next.hop = item_reg.hop_id;
                        wr_next.tim = item_reg.time_stamp;
                        if (tok_end.hit)
                        begin
                            wr_next.en  = 1'b1;
                            wr_next.idx = tok_end.hit_idx;
                            status_next = dtlm_pkg::ST_STORED;
                        end
                        else if (tok_end.free)
                        begin
                            wr_next.en  = 1'b1;
                            wr_next.idx = tok_end.free_idx;
                            status_next = dtlm_pkg::ST_STORED;
                        end
                        else
                        begin
                            status_next = dtlm_pkg::ST_FULL;
                        end
                    end
                    else if (!tok_end.hit)
                    begin
                        cnt_next[typ_reg].unk = dtlm_pkg::sat_add32(cnt_reg[typ_reg].unk,
                                                                    dtlm_pkg::EXP_W'(1));
                        status_next = dtlm_pkg::ST_UNKNOWN;
                    end
                    else
                    begin
                        wr_next.en  = 1'b1;
                        wr_next.idx = tok_end.hit_idx;
                        cnt_next[typ_reg].att = dtlm_pkg::sat_add32(cnt_reg[typ_reg].att,
                                                                    dtlm_pkg::EXP_W'(1));
                        if (negative)
                            rt_next = (diff_neg > dtlm_pkg::RT_NEG_MAG)
                                    ? dtlm_pkg::RT_NEG_MAG : (48'd0 - diff_neg);
                        else
                            rt_next = (diff_pos > dtlm_pkg::RT_POS_MAX)
                                    ? dtlm_pkg::RT_POS_MAX : diff_pos;
                        if (too_long)
                        begin
                            cnt_next[typ_reg].tmo = dtlm_pkg::sat_add32(cnt_reg[typ_reg].tmo,
                                                                        dtlm_pkg::EXP_W'(1));
                            status_next = dtlm_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            cnt_next[typ_reg].sum  = sum_ext[64] ? '1 : sum_ext[63:0];
                            cnt_next[typ_reg].lcnt = dtlm_pkg::sat_add32(
                                cnt_reg[typ_reg].lcnt, dtlm_pkg::EXP_W'(1));
                            if (good_code)
                            begin
                                cnt_next[typ_reg].suc = dtlm_pkg::sat_add32(
                                    cnt_reg[typ_reg].suc, dtlm_pkg::EXP_W'(1));
                                status_next = dtlm_pkg::ST_SUCCESS;
                            end
                            else
                            begin
                                cnt_next[typ_reg].fail = dtlm_pkg::sat_add32(
                                    cnt_reg[typ_reg].fail, dtlm_pkg::EXP_W'(1));
                                status_next = dtlm_pkg::ST_FAIL;
                            end
                        end
                    end
                end
            end
            S_EMIT:
            begin
                result_next.status         = status_reg;
                result_next.msg_type       = typ_reg;
                result_next.round_trip     = rt_reg;
                result_next.attempts_count = cnt_reg[typ_reg].att;
                result_next.success_count  = cnt_reg[typ_reg].suc;
                result_next.fail_count     = cnt_reg[typ_reg].fail;
                result_next.timeout_count  = cnt_reg[typ_reg].tmo;
                result_next.unknown_count  = cnt_reg[typ_reg].unk;
                result_next.latency_sum    = cnt_reg[typ_reg].sum;
                result_next.latency_count  = cnt_reg[typ_reg].lcnt;
                result_next.last           = 1'b1;
                result_valid_next          = 1'b1;
                state_next                 = S_IDLE;
            end
            S_EMIT0:
            begin
                result_next.status         = status_reg;
                result_next.msg_type       = 1'b0;
                result_next.round_trip     = '0;
                result_next.attempts_count = cnt_reg[0].att;
                result_next.success_count  = cnt_reg[0].suc;
                result_next.fail_count     = cnt_reg[0].fail;
                result_next.timeout_count  = cnt_reg[0].tmo;
                result_next.unknown_count  = cnt_reg[0].unk;
                result_next.latency_sum    = cnt_reg[0].sum;
                result_next.latency_count  = cnt_reg[0].lcnt;
                result_next.last           = 1'b0;
                result_valid_next          = 1'b1;
                state_next                 = S_EMIT1;
            end
            S_EMIT1:
            begin
                result_next.status         = status_reg;
                result_next.msg_type       = 1'b1;
                result_next.round_trip     = '0;
                result_next.attempts_count = cnt_reg[1].att;
                result_next.success_count  = cnt_reg[1].suc;
                result_next.fail_count     = cnt_reg[1].fail;
                result_next.timeout_count  = cnt_reg[1].tmo;
                result_next.unknown_count  = cnt_reg[1].unk;
                result_next.latency_sum    = cnt_reg[1].sum;
                result_next.latency_count  = cnt_reg[1].lcnt;
                result_next.last           = 1'b1;
                result_valid_next          = 1'b1;
                state_next                 = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, counters and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tok_start_reg    <= 1'b0;
            wr_reg           <= '0;
            cnt_reg[0]       <= '0;
            cnt_reg[1]       <= '0;
            result_valid_reg <= 1'b0;
            aa_reg           <= 24'd265;
            term_reg         <= 24'd275;
            limit_reg        <= 48'd40000000;
            timeout_reg      <= 48'd40000000;
        end
        else
        begin
            state_reg        <= state_next;
            tok_start_reg    <= tok_start_next;
            wr_reg           <= wr_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    dtlm_pkg::REG_AA_CODE:   aa_reg      <= wr_data[23:0];
                    dtlm_pkg::REG_TERM_CODE: term_reg    <= wr_data[23:0];
                    dtlm_pkg::REG_RTT_LIMIT: limit_reg   <= wr_data;
                    dtlm_pkg::REG_TIMEOUT:   timeout_reg <= wr_data;
                    default:                 aa_reg      <= aa_reg;
                endcase
            end
        end
    end

    // Item payload and result data.
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        typ_reg    <= typ_next;
        status_reg <= status_next;
        rt_reg     <= rt_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // The first of two results is always followed by the second.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid && result.last)
        else $error("second result missing");

    // A scan token leaves the cell row only while the controller waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_end.act |-> state_reg == S_SCAN)
        else $error("stray scan token");

    // A token is launched for a single cycle only.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_start_reg |=> !tok_start_reg)
        else $error("token launched twice");

    // An accepted request either starts work or answers at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy || result_valid)
        else $error("request dropped");
`endif

endmodule

`default_nettype wire
